// File: rtl/lmsd_pkg.sv
// ----------------------------------------------------------------------------
// lmsd_pkg
// Shared constants, codes and types of the led matrix scan driver.
// ----------------------------------------------------------------------------
package lmsd_pkg;

  // panel geometry
  localparam int unsigned PANEL_ROWS = 32;
  localparam int unsigned PANEL_COLS = 192;
  localparam int unsigned HALF_ROWS  = PANEL_ROWS / 2;

  // one frame buffer half holds HALF_ROWS rows of PANEL_COLS pixels
  localparam int unsigned MEM_DEPTH = HALF_ROWS * PANEL_COLS;
  localparam int unsigned MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // scan counters
  localparam int unsigned COL_W   = (PANEL_COLS > 1) ? $clog2(PANEL_COLS) : 1;
  localparam int unsigned RPAIR_W = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;

  // field widths
  localparam int unsigned PIX_ROW_W  = 5;
  localparam int unsigned PIX_COL_W  = 8;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned ROW_ADDR_W = 4;

  // stored pixel: one bit per colour, 1 means lit
  localparam int unsigned PIX_W     = 2;
  localparam int unsigned PIX_RED   = 0;
  localparam int unsigned PIX_GREEN = 1;

  // half-scale threshold on the 8-bit level
  localparam logic [LEVEL_W-1:0] LIT_THRESHOLD = 8'd128;

  // request opcodes
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  // what a tick emits besides the pixel data
  typedef struct packed {
    logic                  latch;
    logic [ROW_ADDR_W-1:0] row_address;
    logic                  frame_end;
  } tick_info_t;

  // write port of the two frame buffer halves
  typedef struct packed {
    logic              upper_en;
    logic              lower_en;
    logic [MEM_AW-1:0] addr;
    logic [PIX_W-1:0]  data;
  } mem_wr_t;

endpackage

// File: rtl/lmsd_in_if.sv
// ----------------------------------------------------------------------------
// lmsd_in_if
// Request channel: pixel writes and scan ticks.
// ----------------------------------------------------------------------------
interface lmsd_in_if;

  logic                                 valid;
  logic                                 ready;
  lmsd_pkg::op_e                        op;
  logic [lmsd_pkg::PIX_ROW_W-1:0]       pixel_row;
  logic [lmsd_pkg::PIX_COL_W-1:0]       pixel_col;
  logic [lmsd_pkg::LEVEL_W-1:0]         red_level;
  logic [lmsd_pkg::LEVEL_W-1:0]         green_level;

  modport source (
    output valid, op, pixel_row, pixel_col, red_level, green_level,
    input  ready
  );

  modport sink (
    input  valid, op, pixel_row, pixel_col, red_level, green_level,
    output ready
  );

endinterface

// File: rtl/lmsd_out_if.sv
// ----------------------------------------------------------------------------
// lmsd_out_if
// Result channel: one panel pin state per scan tick.
// ----------------------------------------------------------------------------
interface lmsd_out_if;

  logic                                 valid;
  logic                                 ready;
  logic                                 upper_red_pin;
  logic                                 upper_green_pin;
  logic                                 lower_red_pin;
  logic                                 lower_green_pin;
  logic                                 shift_pulse;
  logic                                 latch_pulse;
  logic                                 blank;
  logic [lmsd_pkg::ROW_ADDR_W-1:0]      row_address;
  logic                                 frame_end;

  modport source (
    output valid, upper_red_pin, upper_green_pin, lower_red_pin, lower_green_pin,
           shift_pulse, latch_pulse, blank, row_address, frame_end,
    input  ready
  );

  modport sink (
    input  valid, upper_red_pin, upper_green_pin, lower_red_pin, lower_green_pin,
           shift_pulse, latch_pulse, blank, row_address, frame_end,
    output ready
  );

endinterface

// File: rtl/led_matrix_scan_driver_core.sv
// ----------------------------------------------------------------------------
// led_matrix_scan_driver_core
// Scan driver for a split two-colour LED matrix panel. Pixel write requests
// fill a frame buffer kept as two halves (upper and lower rows), each colour
// stored as one bit lit at half scale. Each scan tick request gives one pin
// state result: a shift of one column of both halves, or after the last
// column a blanked latch with the row pair address. One request is taken
// per clock while in_i ready is high; a tick result passes through the
// registered read port of the frame buffer followed by the result register.
// After reset the block clears all HALF_ROWS * PANEL_COLS entries of each
// half (3072 at 32 x 192), one entry of each half per cycle, with in_i
// ready held low; a result waiting on the output does not block new
// requests until both the read stage and the result register are full.
// ----------------------------------------------------------------------------
module led_matrix_scan_driver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  lmsd_in_if.sink     in_i,
  lmsd_out_if.source  out_o
);

  import lmsd_pkg::*;

  logic              clearing;
  logic              stage_ready;
  logic              accept;
  logic              pix_req;
  logic              tick_req;
  mem_wr_t           wr;
  logic [MEM_AW-1:0] rd_addr;
  tick_info_t        info;
  logic [PIX_W-1:0]  upper_px;
  logic [PIX_W-1:0]  lower_px;

  // request acceptance and decode
  assign in_i.ready = !clearing && stage_ready;
  assign accept     = in_i.valid && in_i.ready;
  assign pix_req    = accept && (in_i.op == OP_PIXEL);
  assign tick_req   = accept && (in_i.op == OP_TICK);

  // write path and clearing pass
  lmsd_wr_ctrl u_wr_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_req_i      (pix_req),
    .pixel_row_i   (in_i.pixel_row),
    .pixel_col_i   (in_i.pixel_col),
    .red_level_i   (in_i.red_level),
    .green_level_i (in_i.green_level),
    .wr_o          (wr),
    .clearing_o    (clearing)
  );

  // scan counters
  lmsd_scan_ctrl u_scan_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick_req),
    .rd_addr_o (rd_addr),
    .info_o    (info)
  );

  // frame buffer, upper half rows
  lmsd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram_upper (
    .clk_i   (clk_i),
    .we_i    (wr.upper_en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (tick_req),
    .raddr_i (rd_addr),
    .rdata_o (upper_px)
  );

  // frame buffer, lower half rows
  lmsd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram_lower (
    .clk_i   (clk_i),
    .we_i    (wr.lower_en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (tick_req),
    .raddr_i (rd_addr),
    .rdata_o (lower_px)
  );

  // read stage and result register
  lmsd_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (tick_req),
    .info_i     (info),
    .upper_px_i (upper_px),
    .lower_px_i (lower_px),
    .ready_o    (stage_ready),
    .out_o      (out_o)
  );

endmodule

// File: rtl/lmsd_ram.sv
// ----------------------------------------------------------------------------
// lmsd_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lmsd_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lmsd_wr_ctrl.sv
// ----------------------------------------------------------------------------
// lmsd_wr_ctrl
// Frame buffer write path: pixel thresholding, half select and the
// clearing pass after reset.
// ----------------------------------------------------------------------------
module lmsd_wr_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_req_i,
  input  logic [lmsd_pkg::PIX_ROW_W-1:0]     pixel_row_i,
  input  logic [lmsd_pkg::PIX_COL_W-1:0]     pixel_col_i,
  input  logic [lmsd_pkg::LEVEL_W-1:0]       red_level_i,
  input  logic [lmsd_pkg::LEVEL_W-1:0]       green_level_i,
  output lmsd_pkg::mem_wr_t                  wr_o,
  output logic                               clearing_o
);

  import lmsd_pkg::*;

  localparam int unsigned ROWX_W = PIX_ROW_W + 2;
  localparam int unsigned COLX_W = PIX_COL_W + 1;

  logic              clearing_q, clearing_d;
  logic [MEM_AW-1:0] clr_cnt_q, clr_cnt_d;

  logic [ROWX_W-1:0] row_ext;
  logic [ROWX_W-1:0] row_idx;
  logic              in_upper;
  logic              in_lower;
  logic              col_ok;
  logic [MEM_AW-1:0] px_addr;
  logic [PIX_W-1:0]  px_data;

  // clearing pass, one entry of each half per cycle
  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + MEM_AW'(1);
      if (clr_cnt_q == MEM_AW'(MEM_DEPTH - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // map panel row to a buffer half and a row inside it
  always_comb begin
    row_ext  = ROWX_W'(pixel_row_i);
    in_upper = row_ext < ROWX_W'(HALF_ROWS);
    in_lower = !in_upper && (row_ext < ROWX_W'(2 * HALF_ROWS));
    row_idx  = in_upper ? row_ext : (row_ext - ROWX_W'(HALF_ROWS));
    col_ok   = COLX_W'(pixel_col_i) < COLX_W'(PANEL_COLS);
    px_addr  = MEM_AW'(row_idx) * MEM_AW'(PANEL_COLS) + MEM_AW'(pixel_col_i);
    px_data            = '0;
    px_data[PIX_RED]   = red_level_i >= LIT_THRESHOLD;
    px_data[PIX_GREEN] = green_level_i >= LIT_THRESHOLD;
  end

  // clear pass owns the port until done
  always_comb begin
    if (clearing_q) begin
      wr_o.upper_en = 1'b1;
      wr_o.lower_en = 1'b1;
      wr_o.addr     = clr_cnt_q;
      wr_o.data     = '0;
    end else begin
      wr_o.upper_en = wr_req_i && col_ok && in_upper;
      wr_o.lower_en = wr_req_i && col_ok && in_lower;
      wr_o.addr     = px_addr;
      wr_o.data     = px_data;
    end
  end

  assign clearing_o = clearing_q;

endmodule

// File: rtl/lmsd_scan_ctrl.sv
// ----------------------------------------------------------------------------
// lmsd_scan_ctrl
// Column and row pair counters of the panel scan, read address and
// per-tick control fields.
// ----------------------------------------------------------------------------
module lmsd_scan_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            tick_i,
  output logic [lmsd_pkg::MEM_AW-1:0]     rd_addr_o,
  output lmsd_pkg::tick_info_t            info_o
);

  import lmsd_pkg::*;

  logic [COL_W-1:0]   col_q, col_d;
  logic [RPAIR_W-1:0] rpair_q, rpair_d;
  logic               latch_q, latch_d;
  logic               last_col;
  logic               last_pair;

  assign last_col  = col_q == COL_W'(PANEL_COLS - 1);
  assign last_pair = rpair_q == RPAIR_W'(HALF_ROWS - 1);

  // counter advance per tick
  always_comb begin
    col_d   = col_q;
    rpair_d = rpair_q;
    latch_d = latch_q;
    if (tick_i) begin
      if (latch_q) begin
        latch_d = 1'b0;
        col_d   = '0;
        rpair_d = last_pair ? '0 : (rpair_q + RPAIR_W'(1));
      end else if (last_col) begin
        latch_d = 1'b1;
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      rpair_q <= '0;
      latch_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      rpair_q <= rpair_d;
      latch_q <= latch_d;
    end
  end

  // same address in both halves: upper row and the row half a panel below
  assign rd_addr_o = MEM_AW'(rpair_q) * MEM_AW'(PANEL_COLS) + MEM_AW'(col_q);

  // control fields of the current tick
  always_comb begin
    info_o.latch       = latch_q;
    info_o.row_address = latch_q ? ROW_ADDR_W'(rpair_q) : '0;
    info_o.frame_end   = latch_q && last_pair;
  end

  // latch tick restarts the column scan
  a_latch_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_i && latch_q |=> col_q == '0 && !latch_q)
    else $error("column scan not restarted after latch");

  // last column leads into the latch tick
  a_last_col_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_i && !latch_q && last_col |=> latch_q && $stable(rpair_q))
    else $error("latch phase not entered after last column");

  // counters move only on a tick
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_i |=> $stable(col_q) && $stable(rpair_q) && $stable(latch_q))
    else $error("scan counters moved without a tick");

endmodule

// File: rtl/lmsd_out_stage.sv
// ----------------------------------------------------------------------------
// lmsd_out_stage
// Read stage aligned with the frame buffer read data, and the result
// register that drives the output channel.
// ----------------------------------------------------------------------------
module lmsd_out_stage (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  lmsd_pkg::tick_info_t            info_i,
  input  logic [lmsd_pkg::PIX_W-1:0]      upper_px_i,
  input  logic [lmsd_pkg::PIX_W-1:0]      lower_px_i,
  output logic                            ready_o,
  lmsd_out_if.source                      out_o
);

  import lmsd_pkg::*;

  logic       s1_valid_q, s1_valid_d;
  tick_info_t s1_info_q;
  logic       s1_adv;

  logic                  s2_valid_q, s2_valid_d;
  logic                  ur_q, ug_q, lr_q, lg_q;
  logic                  shift_q, latch_q, blank_q, frame_end_q;
  logic [ROW_ADDR_W-1:0] row_addr_q;

  // read stage moves on when the result register is free or drains
  assign s1_adv  = s1_valid_q && (!s2_valid_q || out_o.ready);
  assign ready_o = !s1_valid_q || !s2_valid_q || out_o.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (load_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (s1_adv) begin
      s2_valid_d = 1'b1;
    end else if (out_o.ready) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // read stage control fields
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_info_q <= info_i;
    end
  end

  // result register, data lines active low and dark while latching
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      ur_q        <= s1_info_q.latch || !upper_px_i[PIX_RED];
      ug_q        <= s1_info_q.latch || !upper_px_i[PIX_GREEN];
      lr_q        <= s1_info_q.latch || !lower_px_i[PIX_RED];
      lg_q        <= s1_info_q.latch || !lower_px_i[PIX_GREEN];
      shift_q     <= !s1_info_q.latch;
      latch_q     <= s1_info_q.latch;
      blank_q     <= s1_info_q.latch;
      row_addr_q  <= s1_info_q.row_address;
      frame_end_q <= s1_info_q.frame_end;
    end
  end

  assign out_o.valid           = s2_valid_q;
  assign out_o.upper_red_pin   = ur_q;
  assign out_o.upper_green_pin = ug_q;
  assign out_o.lower_red_pin   = lr_q;
  assign out_o.lower_green_pin = lg_q;
  assign out_o.shift_pulse     = shift_q;
  assign out_o.latch_pulse     = latch_q;
  assign out_o.blank           = blank_q;
  assign out_o.row_address     = row_addr_q;
  assign out_o.frame_end       = frame_end_q;

  // a new tick never overwrites a read stage that cannot move
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !s1_valid_q || s1_adv)
    else $error("tick loaded over a stalled read stage");

  // stalled read stage keeps its tick
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_valid_q && !out_o.ready |=> s1_valid_q && $stable(s1_info_q))
    else $error("read stage lost a tick under stall");

  // an advancing tick always shows up as a result
  a_s1_to_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> s2_valid_q && (latch_q != shift_q))
    else $error("tick did not reach the result register");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the led matrix scan driver. A short table of
// directed requests covers reset state, threshold edges, out-of-range
// columns and overwrites. A long random run follows that steers pixel
// writes onto the row pair being scanned and keeps ticking across several
// row pairs, so latch ticks and row addresses are seen. Each pin state
// result is checked against an in-bench panel model or, for some directed
// rows, a hand-typed result, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import lmsd_pkg::*;

  localparam int unsigned RANDOM_ITEMS    = 1550;
  localparam int unsigned TICKS_PER_PAIR  = PANEL_COLS + 1;
  localparam int unsigned TICKS_PER_FRAME = HALF_ROWS * TICKS_PER_PAIR;
  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned MAX_REPORTS     = 100;

  // one pin state result as the panel sees it
  typedef struct packed {
    logic                  upper_red;
    logic                  upper_green;
    logic                  lower_red;
    logic                  lower_green;
    logic                  shift;
    logic                  latch;
    logic                  blank;
    logic [ROW_ADDR_W-1:0] row_addr;
    logic                  frame_end;
  } pin_state_t;

  localparam pin_state_t NO_PINS = '0;

  // one request plus an optional hand-typed result
  typedef struct {
    op_e                  op;
    logic [PIX_ROW_W-1:0] row;
    logic [PIX_COL_W-1:0] col;
    logic [LEVEL_W-1:0]   red;
    logic [LEVEL_W-1:0]   green;
    bit                   typed;
    pin_state_t           want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lmsd_in_if  req_if ();
  lmsd_out_if pin_if ();

  led_matrix_scan_driver_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (pin_if)
  );

  always #6 clk_i = ~clk_i;

  // panel model state
  logic [PIX_W-1:0] lit_map [PANEL_ROWS][PANEL_COLS];
  int unsigned      scan_col;
  int unsigned      scan_pair;
  bit               in_latch;

  pin_state_t  pending_pins [$];
  int unsigned mismatches;
  int unsigned ticks_sent;
  bit          calm;
  logic        row_typed;
  pin_state_t  row_want;
  stim_row_t   directed_rows [$];

  // gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic pin_state_t column_pins(logic ur, logic ug, logic lr, logic lg);
    return {ur, ug, lr, lg, 1'b1, 1'b0, 1'b0, 4'd0, 1'b0};
  endfunction

  // panel model: apply one request, report the pin state of a tick
  function automatic void advance_panel(input op_e op, input int unsigned row, col,
                                        input int unsigned red, green,
                                        output bit has_pins, output pin_state_t pins);
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] dn;
    pins     = NO_PINS;
    has_pins = 1'b0;
    if (op == OP_PIXEL) begin
      if (row < PANEL_ROWS && col < PANEL_COLS) begin
        lit_map[row][col][PIX_RED]   = (red >= LIT_THRESHOLD);
        lit_map[row][col][PIX_GREEN] = (green >= LIT_THRESHOLD);
      end
      return;
    end
    has_pins = 1'b1;
    if (!in_latch) begin
      up = lit_map[scan_pair][scan_col];
      dn = lit_map[scan_pair + HALF_ROWS][scan_col];
      pins = column_pins(~up[PIX_RED], ~up[PIX_GREEN], ~dn[PIX_RED], ~dn[PIX_GREEN]);
      scan_col++;
      if (scan_col >= PANEL_COLS) in_latch = 1'b1;
    end else begin
      pins.upper_red   = 1'b1;
      pins.upper_green = 1'b1;
      pins.lower_red   = 1'b1;
      pins.lower_green = 1'b1;
      pins.latch       = 1'b1;
      pins.blank       = 1'b1;
      pins.row_addr    = ROW_ADDR_W'(scan_pair);
      pins.frame_end   = (scan_pair + 1 >= HALF_ROWS);
      scan_col  = 0;
      in_latch  = 1'b0;
      scan_pair = (scan_pair + 1 >= HALF_ROWS) ? 0 : scan_pair + 1;
    end
  endfunction

  function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
    if (want !== got) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // drive one request and hold it until it is taken
  task automatic send_request(input stim_row_t s, input bit drain);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (drain || gap != 0) begin
      req_if.valid <= 1'b0;
      if (drain) begin
        @(posedge clk_i);
        while (pending_pins.size() != 0) @(posedge clk_i);
      end
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.op          <= s.op;
    req_if.pixel_row   <= s.row;
    req_if.pixel_col   <= s.col;
    req_if.red_level   <= s.red;
    req_if.green_level <= s.green;
    row_typed          <= s.typed;
    row_want           <= s.want;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    if (s.op == OP_TICK) ticks_sent++;
  endtask

  task automatic add_row(input op_e op, input int unsigned row, col, red, green,
                         input bit typed, input pin_state_t want);
    stim_row_t s;
    s.op    = op;
    s.row   = PIX_ROW_W'(row);
    s.col   = PIX_COL_W'(col);
    s.red   = LEVEL_W'(red);
    s.green = LEVEL_W'(green);
    s.typed = typed;
    s.want  = want;
    directed_rows.push_back(s);
  endtask

  // result checking, request tracking and result back-pressure
  always @(posedge clk_i) begin : scoreboard
    pin_state_t  got;
    pin_state_t  want;
    pin_state_t  model_pins;
    bit          has_pins;
    int unsigned hold_left;
    if (rst_ni) begin
      if (pin_if.valid === 1'b1 && pin_if.ready === 1'b1) begin
        got.upper_red   = pin_if.upper_red_pin;
        got.upper_green = pin_if.upper_green_pin;
        got.lower_red   = pin_if.lower_red_pin;
        got.lower_green = pin_if.lower_green_pin;
        got.shift       = pin_if.shift_pulse;
        got.latch       = pin_if.latch_pulse;
        got.blank       = pin_if.blank;
        got.row_addr    = pin_if.row_address;
        got.frame_end   = pin_if.frame_end;
        if (pending_pins.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t ns: unexpected result, expected none, got %h", $time, got);
          mismatches++;
        end else begin
          want = pending_pins.pop_front();
          check_field("upper_red_pin", want.upper_red, got.upper_red);
          check_field("upper_green_pin", want.upper_green, got.upper_green);
          check_field("lower_red_pin", want.lower_red, got.lower_red);
          check_field("lower_green_pin", want.lower_green, got.lower_green);
          check_field("shift_pulse", want.shift, got.shift);
          check_field("latch_pulse", want.latch, got.latch);
          check_field("blank", want.blank, got.blank);
          check_field("row_address", want.row_addr, got.row_addr);
          check_field("frame_end", want.frame_end, got.frame_end);
        end
      end

      if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
        advance_panel(req_if.op, req_if.pixel_row, req_if.pixel_col,
                      req_if.red_level, req_if.green_level, has_pins, model_pins);
        if (has_pins) pending_pins.push_back(row_typed ? row_want : model_pins);
      end

      // result stalls, none while calm
      if (hold_left != 0) begin
        pin_if.ready <= 1'b0;
        hold_left--;
      end else begin
        pin_if.ready <= 1'b1;
        hold_left = calm ? 0 : pick_gap();
      end
    end else begin
      // model back to its reset state, every pixel dark
      for (int r = 0; r < PANEL_ROWS; r++)
        for (int c = 0; c < PANEL_COLS; c++)
          lit_map[r][c] = '0;
      scan_col     = 0;
      scan_pair    = 0;
      in_latch     = 1'b0;
      mismatches   = 0;
      hold_left    = 0;
      pending_pins.delete();
      pin_if.ready <= 1'b0;
    end
  end

  // stall guard
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t ns: timeout after %0d cycles", $time, CYCLE_LIMIT);
    $display("** led_matrix_scan_driver_core: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned pos;
    int unsigned pair;
    int unsigned col_now;
    int unsigned pick;
    stim_row_t   s;

    ticks_sent = 0;

    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.op          <= OP_PIXEL;
    req_if.pixel_row   <= '0;
    req_if.pixel_col   <= '0;
    req_if.red_level   <= '0;
    req_if.green_level <= '0;
    calm               <= 1'b0;
    row_typed          <= 1'b0;
    row_want           <= NO_PINS;

    // directed: cleared buffer, threshold edges, overwrite, out-of-range columns
    add_row(OP_TICK,   0,   0,   0,   0, 1'b1, column_pins(1'b1, 1'b1, 1'b1, 1'b1));
    add_row(OP_PIXEL,  0,   1, 128, 127, 1'b0, NO_PINS);
    add_row(OP_PIXEL, 16,   1, 127, 255, 1'b0, NO_PINS);
    add_row(OP_PIXEL,  0,   2, 255, 255, 1'b0, NO_PINS);
    add_row(OP_PIXEL, 16,   2,   0,   0, 1'b0, NO_PINS);
    add_row(OP_PIXEL,  0,   3, 200, 200, 1'b0, NO_PINS);
    add_row(OP_PIXEL,  0,   3,   0,   0, 1'b0, NO_PINS);
    add_row(OP_PIXEL,  0, 192, 255, 255, 1'b0, NO_PINS);
    add_row(OP_PIXEL, 16, 255, 255, 255, 1'b0, NO_PINS);
    add_row(OP_PIXEL, 31, 191, 255, 128, 1'b0, NO_PINS);
    add_row(OP_PIXEL, 15, 191, 128, 255, 1'b0, NO_PINS);
    add_row(OP_PIXEL, 15,   0,   0, 255, 1'b0, NO_PINS);
    add_row(OP_PIXEL,  0,   4, 255,   0, 1'b0, NO_PINS);
    add_row(OP_PIXEL, 16,   4, 129, 129, 1'b0, NO_PINS);
    add_row(OP_TICK,   0,   0,   0,   0, 1'b1, column_pins(1'b0, 1'b1, 1'b1, 1'b0));
    add_row(OP_TICK,   0,   0,   0,   0, 1'b1, column_pins(1'b0, 1'b0, 1'b1, 1'b1));
    add_row(OP_TICK,   0,   0,   0,   0, 1'b1, column_pins(1'b1, 1'b1, 1'b1, 1'b1));
    add_row(OP_TICK,  31, 255, 255, 255, 1'b0, NO_PINS);
    add_row(OP_PIXEL,  0,   5, 127, 128, 1'b0, NO_PINS);
    add_row(OP_TICK,   0,   0,   0,   0, 1'b0, NO_PINS);
    add_row(OP_PIXEL, 16,   6, 255, 255, 1'b0, NO_PINS);
    add_row(OP_TICK,   0,   0,   0,   0, 1'b0, NO_PINS);
    add_row(OP_TICK,   0,   0,   0,   0, 1'b0, NO_PINS);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) send_request(directed_rows[i], 1'b0);

    // random: mostly ticks, writes aimed at the row pair under scan
    s.typed = 1'b0;
    s.want  = NO_PINS;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 128 == 0) calm <= ($urandom_range(0, 3) == 0);
      pos     = ticks_sent % TICKS_PER_FRAME;
      pair    = pos / TICKS_PER_PAIR;
      col_now = pos % TICKS_PER_PAIR;
      s.row   = PIX_ROW_W'($urandom);
      s.col   = PIX_COL_W'($urandom);
      s.red   = ($urandom_range(0, 3) == 0) ? LEVEL_W'($urandom_range(120, 135))
                                            : LEVEL_W'($urandom);
      s.green = ($urandom_range(0, 3) == 0) ? LEVEL_W'($urandom_range(120, 135))
                                            : LEVEL_W'($urandom);
      if ($urandom_range(0, 99) < 85) begin
        s.op = OP_TICK;
      end else begin
        s.op = OP_PIXEL;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          s.row = PIX_ROW_W'(pair + ($urandom_range(0, 1) ? HALF_ROWS : 0));
          s.col = PIX_COL_W'((col_now + $urandom_range(0, 12) > PANEL_COLS - 1)
                             ? PANEL_COLS - 1 : col_now + $urandom_range(0, 12));
        end else if (pick < 82) begin
          s.col = PIX_COL_W'($urandom_range(PANEL_COLS, 255));
        end
      end
      send_request(s, (n == RANDOM_ITEMS / 2) || ($urandom_range(0, 399) == 0));
    end

    // drain and let the pipeline settle
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_pins.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** led_matrix_scan_driver_core: PASSED **");
    end else begin
      $display("** led_matrix_scan_driver_core: FAILED **");
    end
    $finish;
  end

endmodule
